// File: rtl/gps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gps_pkg: shared types, constants and arithmetic steps
// Payload structs, queue entry, register indexes and the single-step
// functions used by the square root, divider and log2 pipelines.
// ----------------------------------------------------------------------------
package gps_pkg;

   localparam int unsigned WORD_W = 32;

   // ln(2) as a 32-bit fraction
   localparam logic [WORD_W-1:0] LN2_Q32 = 32'hB17217F8;

   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_OFFSET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STD_SCALE = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] first_uniform;
      logic [WORD_W-1:0] second_uniform;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] normal_sample;
      logic clipped;
   } rsp_type;

   // s as Q0.62, |v1| as Q0.31, sign of v1
   typedef struct packed {
      logic [61:0] s;
      logic [WORD_W-1:0] mag;
      logic neg;
   } qent_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic [63:0] x;
      logic [63:0] r;
   } root_type;

   typedef struct packed {
      logic [31:0] m;
      logic [31:0] l;
   } logacc_type;

   typedef struct packed {
      logic [62:0] rem;
      logic [31:0] quo;
   } divacc_type;

   // one digit of the restoring integer square root
   function automatic root_type sqrt_step(root_type st, logic [63:0] b);
      logic [64:0] trial;
      root_type o;
      trial = {1'b0, st.r} + {1'b0, b};
      if ({1'b0, st.x} >= trial) begin
         o.x = st.x - trial[63:0];
         o.r = (st.r >> 1) + b;
      end else begin
         o.x = st.x;
         o.r = st.r >> 1;
      end
      return o;
   endfunction

   // one fraction bit of log2 by squaring
   function automatic logacc_type log_step(logacc_type st);
      logic [63:0] sqr;
      logacc_type o;
      sqr = 64'(st.m) * 64'(st.m);
      o.m = sqr[63] ? sqr[63:32] : sqr[62:31];
      o.l = {st.l[30:0], sqr[63]};
      return o;
   endfunction

   // one quotient bit of restoring division
   function automatic divacc_type div_step(divacc_type d, logic [62:0] sub);
      divacc_type o;
      o = d;
      if (d.rem >= sub) begin
         o.rem = d.rem - sub;
         o.quo = {d.quo[30:0], 1'b1};
      end else begin
         o.quo = {d.quo[30:0], 1'b0};
      end
      return o;
   endfunction

endpackage
`default_nettype wire

// File: rtl/gps_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gps_front: input stage
// Maps the uniform pair to magnitudes, forms s and drops rejected pairs.
// ----------------------------------------------------------------------------
module gps_front #(
   parameter int unsigned UNIFORM_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  gps_pkg::req_type   req_payload,
   input  gps_pkg::qstat_type qstat,
   output logic               push,
   output gps_pkg::qent_type  push_data
);
   import gps_pkg::*;

   localparam int unsigned DROP_BITS = WORD_W - UNIFORM_BITS;
   localparam logic [WORD_W-1:0] KEEP_MASK = ~((WORD_W'(1) << DROP_BITS) - WORD_W'(1));
   localparam logic [WORD_W-1:0] HALF = WORD_W'(1) << (WORD_W - 1);

   logic              f1_vld_ff, f2_vld_ff;
   logic [WORD_W-1:0] f1_mag1_ff, f1_mag2_ff, f2_mag_ff;
   logic              f1_neg_ff, f2_neg_ff;
   logic [63:0]       f2_sq1_ff, f2_sq2_ff;
   logic [WORD_W-1:0] u1, u2, mag1_in, mag2_in;
   logic              neg_in, advance, keep;
   logic [63:0]       s_sum;

   always_comb begin
      u1 = req_payload.first_uniform & KEEP_MASK;
      u2 = req_payload.second_uniform & KEEP_MASK;
      neg_in = !u1[WORD_W-1];
      mag1_in = u1[WORD_W-1] ? (u1 - HALF) : (HALF - u1);
      mag2_in = u2[WORD_W-1] ? (u2 - HALF) : (HALF - u2);
   end

   // reject s == 0 and s >= 1
   assign s_sum = f2_sq1_ff + f2_sq2_ff;
   assign keep = (s_sum != 64'd0) && (s_sum[63:62] == 2'b00);
   assign advance = !(f2_vld_ff && keep && qstat.full);
   assign req_ready = advance;
   assign push = f2_vld_ff && keep && !qstat.full;
   assign push_data = '{s: s_sum[61:0], mag: f2_mag_ff, neg: f2_neg_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else if (advance) begin
         f1_vld_ff <= req_valid;
         f2_vld_ff <= f1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_mag1_ff <= mag1_in;
         f1_mag2_ff <= mag2_in;
         f1_neg_ff  <= neg_in;
         f2_sq1_ff  <= 64'(f1_mag1_ff) * 64'(f1_mag1_ff);
         f2_sq2_ff  <= 64'(f1_mag2_ff) * 64'(f1_mag2_ff);
         f2_mag_ff  <= f1_mag1_ff;
         f2_neg_ff  <= f1_neg_ff;
      end
   end

endmodule
`default_nettype wire

// File: rtl/gps_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gps_queue: short fifo between front and back
// Four entries of accepted pairs.
// ----------------------------------------------------------------------------
module gps_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  gps_pkg::qent_type  push_data,
   input  logic               pop,
   output gps_pkg::qent_type  pop_data,
   output gps_pkg::qstat_type qstat
);
   import gps_pkg::*;

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(DEPTH);

   qent_type         fifo_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff, count_in;

   assign qstat.full = (count_ff == (PTR_W+1)'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_data = fifo_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) fifo_ff[wr_ptr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full) else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty) else $error("queue read while empty");

endmodule
`default_nettype wire

// File: rtl/gps_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gps_back: arithmetic pipeline
// Normalise, sqrt(s) with log2(s), ln, divide with sqrt(-2 ln s), scale.
// ----------------------------------------------------------------------------
module gps_back (
   input  logic                clock,
   input  logic                reset,
   input  gps_pkg::qstat_type  qstat,
   input  gps_pkg::qent_type   pop_data,
   output logic                pop,
   input  logic [31:0]         mean_offset,
   input  logic [31:0]         std_scale,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output gps_pkg::rsp_type    rsp_payload
);
   import gps_pkg::*;

   localparam int unsigned NORM_LAST = 5;
   localparam int unsigned STEPS = 32;
   localparam int unsigned CORE0 = NORM_LAST + 1;
   localparam int unsigned LN_A = CORE0 + STEPS + 1;
   localparam int unsigned LN_B = LN_A + 1;
   localparam int unsigned PAIR0 = LN_B + 1;
   localparam int unsigned SC_A = PAIR0 + STEPS + 1;
   localparam int unsigned SC_B = SC_A + 1;
   localparam int unsigned SC_C = SC_B + 1;
   localparam int unsigned OUT = SC_C + 1;

   typedef struct packed {
      logic [63:0] s;
      logic [31:0] a;
      logic [4:0]  k;
      logic        neg;
   } norm_type;

   typedef struct packed {
      root_type    root;
      logacc_type  lg;
      logic [31:0] a;
      logic [6:0]  e;
      logic        neg;
   } core_type;

   typedef struct packed {
      logic [38:0] nl;
      logic [31:0] sq;
      logic [31:0] a;
      logic        neg;
   } lna_type;

   typedef struct packed {
      logic [63:0] prod;
      logic [6:0]  nlhi;
      logic [31:0] sq;
      logic [31:0] a;
      logic        neg;
   } lnb_type;

   typedef struct packed {
      root_type    root;
      divacc_type  dv;
      logic [31:0] sq;
      logic        neg;
   } pair_type;

   typedef struct packed {
      logic [63:0] zp;
      logic        neg;
   } sca_type;

   typedef struct packed {
      logic [63:0] lo;
      logic [36:0] hi;
      logic        neg;
   } scb_type;

   typedef struct packed {
      logic [37:0] q;
      logic        neg;
   } scc_type;

   logic [OUT:0] vld_ff;
   logic         adv;

   norm_type norm_ff [0:NORM_LAST];
   norm_type norm_in [0:NORM_LAST];
   core_type core_ff [0:STEPS];
   core_type core_in [0:STEPS];
   lna_type  lna_ff, lna_in;
   lnb_type  lnb_ff, lnb_in;
   pair_type pair_ff [0:STEPS];
   pair_type pair_in [0:STEPS];
   sca_type  sca_ff, sca_in;
   scb_type  scb_ff, scb_in;
   scc_type  scc_ff, scc_in;
   rsp_type  rsp_ff, rsp_in;

   // whole pipeline moves together when the output slot frees
   assign adv = !vld_ff[OUT] || rsp_ready;
   assign pop = adv && !qstat.empty;
   assign rsp_valid = vld_ff[OUT];
   assign rsp_payload = rsp_ff;

   // normalise s into [2^60, 2^62) by pairs of bits
   always_comb begin
      int sh;
      norm_in[0] = '{s: {2'b00, pop_data.s}, a: pop_data.mag, k: 5'd0, neg: pop_data.neg};
      for (int j = 1; j <= NORM_LAST; j++) begin
         sh = 16 >> (j - 1);
         norm_in[j] = norm_ff[j-1];
         if ((norm_ff[j-1].s >> (62 - 2*sh)) == 64'd0) begin
            norm_in[j].s = norm_ff[j-1].s << (2*sh);
            norm_in[j].a = norm_ff[j-1].a << sh;
            norm_in[j].k = norm_ff[j-1].k + 5'(sh);
         end
      end
   end

   // sqrt(s) and log2(s) side by side
   always_comb begin
      core_in[0].root.x = norm_ff[NORM_LAST].s;
      core_in[0].root.r = 64'd0;
      core_in[0].lg.m = norm_ff[NORM_LAST].s[61] ? norm_ff[NORM_LAST].s[61:30]
                                                 : norm_ff[NORM_LAST].s[60:29];
      core_in[0].lg.l = 32'd0;
      core_in[0].a = norm_ff[NORM_LAST].a;
      core_in[0].e = {1'b0, norm_ff[NORM_LAST].k, 1'b0}
                     + (norm_ff[NORM_LAST].s[61] ? 7'd1 : 7'd2);
      core_in[0].neg = norm_ff[NORM_LAST].neg;
      for (int n = 1; n <= STEPS; n++) begin
         core_in[n] = core_ff[n-1];
         core_in[n].root = sqrt_step(core_ff[n-1].root, 64'd1 << (64 - 2*n));
         core_in[n].lg = log_step(core_ff[n-1].lg);
      end
   end

   // -log2(s) then times ln 2
   always_comb begin
      lna_in.nl = {core_ff[STEPS].e, 32'd0} - {7'd0, core_ff[STEPS].lg.l};
      lna_in.sq = core_ff[STEPS].root.r[31:0];
      lna_in.a = core_ff[STEPS].a;
      lna_in.neg = core_ff[STEPS].neg;
      lnb_in.prod = 64'(lna_ff.nl[31:0]) * 64'(LN2_Q32);
      lnb_in.nlhi = lna_ff.nl[38:32];
      lnb_in.sq = lna_ff.sq;
      lnb_in.a = lna_ff.a;
      lnb_in.neg = lna_ff.neg;
   end

   // |v1|/sqrt(s) and sqrt(-2 ln s) side by side
   always_comb begin
      logic [39:0] ln;
      ln = 40'(lnb_ff.nlhi) * 40'(LN2_Q32) + 40'(lnb_ff.prod[63:32]);
      pair_in[0].root.x = 64'(ln) << 25;
      pair_in[0].root.r = 64'd0;
      pair_in[0].dv.rem = {lnb_ff.a, 31'd0};
      pair_in[0].dv.quo = 32'd0;
      pair_in[0].sq = lnb_ff.sq;
      pair_in[0].neg = lnb_ff.neg;
      for (int n = 1; n <= STEPS; n++) begin
         pair_in[n] = pair_ff[n-1];
         pair_in[n].root = sqrt_step(pair_ff[n-1].root, 64'd1 << (64 - 2*n));
         pair_in[n].dv = div_step(pair_ff[n-1].dv, 63'(pair_ff[n-1].sq) << (32 - n));
      end
   end

   // scale by sigma, round, add mu and saturate
   always_comb begin
      logic signed [39:0] mu, qs, sum;
      sca_in.zp = 64'(pair_ff[STEPS].dv.quo) * 64'(pair_ff[STEPS].root.r[31:0]);
      sca_in.neg = pair_ff[STEPS].neg;
      scb_in.lo = 64'(std_scale) * 64'(sca_ff.zp[58:27]);
      scb_in.hi = 37'(std_scale) * 37'(sca_ff.zp[63:59]);
      scb_in.neg = sca_ff.neg;
      scc_in.q = 38'(scb_ff.hi) + 38'(({1'b0, scb_ff.lo[63:31]} + 34'd1) >> 1);
      scc_in.neg = scb_ff.neg;
      mu = 40'(signed'(mean_offset));
      qs = signed'({2'b00, scc_ff.q});
      sum = scc_ff.neg ? (mu - qs) : (mu + qs);
      if (sum > 40'sh007FFFFFFF) begin
         rsp_in.normal_sample = 32'sh7FFFFFFF;
         rsp_in.clipped = 1'b1;
      end else if (sum < -40'sh0080000000) begin
         rsp_in.normal_sample = 32'sh80000000;
         rsp_in.clipped = 1'b1;
      end else begin
         rsp_in.normal_sample = sum[31:0];
         rsp_in.clipped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[OUT-1:0], pop};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= NORM_LAST; i++) norm_ff[i] <= norm_in[i];
         for (int i = 0; i <= STEPS; i++) begin
            core_ff[i] <= core_in[i];
            pair_ff[i] <= pair_in[i];
         end
         lna_ff <= lna_in;
         lnb_ff <= lnb_in;
         sca_ff <= sca_in;
         scb_ff <= scb_in;
         scc_ff <= scc_in;
         rsp_ff <= rsp_in;
      end
   end

   a_log_norm: assert property (@(posedge clock) disable iff (reset)
      vld_ff[CORE0] |-> core_ff[0].lg.m[31]) else $error("log2 input not normalised");
   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      vld_ff[PAIR0 + STEPS] |-> (pair_ff[STEPS].root.r[63:32] == 32'd0))
      else $error("square root wider than 32 bits");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      vld_ff[PAIR0 + STEPS] |-> (pair_ff[STEPS].dv.rem < 63'(pair_ff[STEPS].sq)))
      else $error("division remainder not below divisor");

endmodule
`default_nettype wire

// File: rtl/gaussian_polar_sampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_polar_sampler: fixed-point polar-method normal generator
// Turns pairs of uniform words into mu + sigma * z samples in Q16.16.
// ----------------------------------------------------------------------------
// usage
//  - req channel (valid/ready): one item is a pair of 32-bit uniform words
//  - pairs whose s is zero or not below one are dropped and give no item
//  - rsp channel (valid/ready): one item per kept pair, sample plus clip flag
//  - csr port: write-only, index 0 mean (signed Q16.16), index 1 sigma
//    (unsigned Q16.16); write only while no items are in flight
//  - throughput: one item per cycle while rsp_ready is held high, items fully pipelined
//  - a kept pair passes the front registers, the queue and the 32-step square root,
//    log2 and divider pipelines in the back end on its way to rsp_valid
//  - a stalled receiver freezes the back pipeline; the 4-entry queue then
//    fills and req_ready drops while the front stage holds a kept pair
//  - reset clears all valid state, mean to zero and sigma to one
// ----------------------------------------------------------------------------
module gaussian_polar_sampler #(
   parameter int unsigned UNIFORM_BITS  = 32,
   parameter int unsigned FRACTION_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  gps_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output gps_pkg::rsp_type                rsp_payload,
   input  logic                            csr_we,
   input  logic [gps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gps_pkg::WORD_W-1:0]      csr_wdata
);
   import gps_pkg::*;

   // sigma resets to 1.0
   localparam logic [WORD_W-1:0] STD_RESET = WORD_W'(1) << FRACTION_BITS;

   logic [WORD_W-1:0] mean_offset_ff, std_scale_ff;
   logic              push, pop;
   qent_type          push_data, pop_data;
   qstat_type         qstat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_offset_ff <= '0;
         std_scale_ff   <= STD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MEAN_OFFSET: mean_offset_ff <= csr_wdata;
            CSR_STD_SCALE:   std_scale_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: magnitudes, s and rejection
   gps_front #(
      .UNIFORM_BITS(UNIFORM_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .qstat      (qstat),
      .push       (push),
      .push_data  (push_data)
   );

   // decoupling queue
   gps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .pop_data (pop_data),
      .qstat    (qstat)
   );

   // back: transcendental pipeline and output register
   gps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .pop_data   (pop_data),
      .pop        (pop),
      .mean_offset(mean_offset_ff),
      .std_scale  (std_scale_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule
`default_nettype wire

// File: tb/gaussian_polar_sampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_polar_sampler_tb: self-checking bench for the polar normal sampler
// Sends uniform pairs through the request channel in bursts, predicts the
// kept samples in fixed point and checks every response field. Mean and sigma
// are swept over several settings, the extremes among them.
// ----------------------------------------------------------------------------
module gaussian_polar_sampler_tb;
   import gps_pkg::*;

   localparam int unsigned ITEMS_PER_PHASE = 320;
   localparam int unsigned SETTLE_CYCLES = 100;
   localparam longint unsigned CYCLE_LIMIT = 600000;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_DROP, ROW_KNOWN} row_kind_type;

   typedef struct {
      logic [31:0] u1;
      logic [31:0] u2;
      row_kind_type kind;
      logic [31:0] sample;
      logic clip;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0] csr_wdata = '0;

   // model copies of the registers
   logic [31:0] mean_q = 32'h0;
   logic [31:0] sigma_q = 32'h0001_0000;

   rsp_type samples_due[$];
   stim_row_type rows_sent[$];
   int unsigned error_count = 0;
   longint unsigned cycle_count = 0;

   gaussian_polar_sampler uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("gaussian_polar_sampler_tb: errors");
         $finish;
      end
   end

   task automatic report(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // integer square root, digit by digit
   function automatic logic [63:0] int_root(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 32 fraction bits of log2(m), m in [1,2) as Q1.31
   function automatic logic [63:0] log2_bits(logic [63:0] m);
      logic [63:0] l;
      l = 0;
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 31;
         l = l << 1;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            l = l | 64'd1;
         end
      end
      return l;
   endfunction

   // polar method sample for one pair; returns 0 when the pair is dropped
   function automatic bit gaussian_sample(input req_type p, output rsp_type o);
      logic [63:0] half, a1, a2, s_raw, sn, a, sq, c, m, l, nl, ln, r, h, zr, q, lo;
      logic signed [63:0] mu, sum;
      logic neg;
      int k, msb, e;
      half = 64'd1 << 31;
      neg = {32'd0, p.first_uniform} < half;
      a1 = neg ? half - p.first_uniform : p.first_uniform - half;
      a2 = ({32'd0, p.second_uniform} < half) ? half - p.second_uniform
                                               : p.second_uniform - half;
      s_raw = a1 * a1 + a2 * a2;
      o = '0;
      if (s_raw == 0 || s_raw >= (64'd1 << 62)) return 0;
      // normalise s into [2^60, 2^62), |v1| follows at half the shift
      sn = s_raw;
      a = a1;
      k = 0;
      while (sn < (64'd1 << 60)) begin
         sn = sn << 2;
         a = a << 1;
         k++;
      end
      sq = int_root(sn);
      c = (a << 31) / sq;
      msb = (sn >= (64'd1 << 61)) ? 61 : 60;
      m = sn >> (msb - 31);
      e = 62 + 2 * k - msb;
      l = log2_bits(m);
      nl = (64'(e) << 32) - l;
      ln = (nl >> 32) * 64'(LN2_Q32) + (((nl & 64'hFFFF_FFFF) * 64'(LN2_Q32)) >> 32);
      r = ln << 1;
      h = int_root(r << 24);
      zr = (c * h) >> 27;
      // sigma scaling, rounded half away from zero once the sign goes on
      lo = 64'(sigma_q) * (zr & 64'hFFFF_FFFF);
      q = 64'(sigma_q) * (zr >> 32) + (((lo >> 31) + 1) >> 1);
      mu = 64'(signed'(mean_q));
      sum = neg ? mu - signed'(q) : mu + signed'(q);
      o.clipped = 1'b0;
      if (sum > 64'sh7FFF_FFFF) begin
         sum = 64'sh7FFF_FFFF;
         o.clipped = 1'b1;
      end else if (sum < -64'sh8000_0000) begin
         sum = -64'sh8000_0000;
         o.clipped = 1'b1;
      end
      o.normal_sample = sum[31:0];
      return 1;
   endfunction

   // request side: work out what each accepted item should give
   always @(posedge clock) begin
      rsp_type exp_rsp;
      stim_row_type row;
      bit kept;
      if (!reset && req_valid && req_ready) begin
         row = rows_sent.pop_front();
         kept = gaussian_sample(req_payload, exp_rsp);
         if (row.kind == ROW_DROP) begin
            if (kept) report("table row expects a drop, predictor keeps it");
         end else if (row.kind == ROW_KNOWN) begin
            exp_rsp.normal_sample = row.sample;
            exp_rsp.clipped = row.clip;
            samples_due.push_back(exp_rsp);
         end else if (kept) begin
            samples_due.push_back(exp_rsp);
         end
      end
   end

   // response side: compare against the oldest expected sample
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (samples_due.size() == 0) begin
            report($sformatf("unexpected item %h", rsp_payload));
         end else begin
            want = samples_due.pop_front();
            if (rsp_payload.normal_sample !== want.normal_sample)
               report($sformatf("sample %h, want %h",
                  rsp_payload.normal_sample, want.normal_sample));
            if (rsp_payload.clipped !== want.clipped)
               report($sformatf("clipped %b, want %b",
                  rsp_payload.clipped, want.clipped));
         end
      end
   end

   // receiver stalls: segments of always ready, coin flips, long stalls
   always @(posedge clock) begin
      int unsigned seg_left, mode;
      if (seg_left == 0) begin
         seg_left = $urandom_range(200, 10);
         mode = $urandom_range(2, 0);
      end
      seg_left--;
      case (mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(1, 0);
         default: rsp_ready <= ($urandom_range(7, 0) == 0);
      endcase
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MEAN_OFFSET) mean_q = val;
      else sigma_q = val;
   endtask

   // wait for every expected sample, then let dropped pairs drain too
   task automatic drain();
      // let the request side first put the last accepted item on the expected list
      @(posedge clock);
      while (samples_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // sender: one item, held until accepted
   int unsigned burst_left = 0;
   task automatic send_pair(input stim_row_type row);
      req_type p;
      if (burst_left == 0) begin
         // gap between bursts, sometimes none
         if ($urandom_range(3, 0) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clock);
         end
         burst_left = $urandom_range(40, 1);
      end
      burst_left--;
      p.first_uniform = row.u1;
      p.second_uniform = row.u2;
      rows_sent.push_back(row);
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic stim_row_type random_row();
      stim_row_type row;
      int unsigned pick;
      pick = $urandom_range(99, 0);
      row.kind = ROW_PREDICT;
      row.sample = 0;
      row.clip = 0;
      if (pick < 70) begin
         row.u1 = $urandom();
         row.u2 = $urandom();
      end else if (pick < 85) begin
         // tiny s, deep normalisation
         row.u1 = 32'h8000_0000 + $urandom_range(1 << $urandom_range(20, 0), 0)
                  - $urandom_range(1 << $urandom_range(20, 0), 0);
         row.u2 = 32'h8000_0000 + $urandom_range(1 << $urandom_range(12, 0), 0)
                  - $urandom_range(1 << $urandom_range(12, 0), 0);
      end else begin
         // near the unit circle: one coordinate close to an edge
         row.u1 = ($urandom_range(1, 0) ? 32'hFFFF_FFFF - $urandom_range(4095, 0)
                                         : $urandom_range(4095, 0));
         row.u2 = 32'h8000_0000 ^ ($urandom() >> $urandom_range(31, 4));
      end
      return row;
   endfunction

   // directed rows under reset registers (mean 0, sigma 1.0)
   stim_row_type dir_rows[] = '{
      '{32'h8000_0000, 32'h8000_0000, ROW_DROP,    0, 0},  // s zero
      '{32'h0000_0000, 32'h0000_0000, ROW_DROP,    0, 0},  // corner, s two
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, ROW_DROP,    0, 0},
      '{32'h0000_0000, 32'h8000_0000, ROW_DROP,    0, 0},  // s exactly one
      '{32'h8000_0000, 32'h4000_0000, ROW_KNOWN,   0, 0},  // v1 zero gives mu
      '{32'h8000_0000, 32'h0000_0001, ROW_KNOWN,   0, 0},
      '{32'h8000_0000, 32'hFFFF_FFFF, ROW_KNOWN,   0, 0},
      '{32'h8000_0001, 32'h8000_0000, ROW_PREDICT, 0, 0},  // smallest s
      '{32'h7FFF_FFFF, 32'h8000_0000, ROW_PREDICT, 0, 0},
      '{32'h8000_0001, 32'h8000_0001, ROW_PREDICT, 0, 0},
      '{32'hFFFF_FFFF, 32'h8000_0000, ROW_PREDICT, 0, 0},  // s just below one
      '{32'h0000_0001, 32'h8000_0000, ROW_PREDICT, 0, 0},
      '{32'hC000_0000, 32'hC000_0000, ROW_PREDICT, 0, 0},
      '{32'h4000_0000, 32'h4000_0000, ROW_PREDICT, 0, 0},
      '{32'hA000_0000, 32'h6000_0000, ROW_PREDICT, 0, 0},
      '{32'h5555_5555, 32'hAAAA_AAAA, ROW_PREDICT, 0, 0},
      '{32'hAAAA_AAAA, 32'h5555_5555, ROW_PREDICT, 0, 0},
      '{32'h8000_FFFF, 32'h7FFF_0000, ROW_PREDICT, 0, 0},
      '{32'h7FFF_0001, 32'h8000_FFFF, ROW_PREDICT, 0, 0}
   };

   // register settings per random phase: mean, sigma
   logic [31:0] phase_mean[] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                 32'hFFFE_8000, 32'h0003_2000};
   logic [31:0] phase_sigma[] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'h0000_0001, 32'h0002_8000};

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_pair(dir_rows[i]);
      req_valid <= 1'b0;
      burst_left = 0;
      drain();

      // sigma zero gives mu, extremes clip, then a few ordinary settings
      foreach (phase_mean[ph]) begin
         csr_write(CSR_MEAN_OFFSET, phase_mean[ph]);
         csr_write(CSR_STD_SCALE, phase_sigma[ph]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_pair(random_row());
         req_valid <= 1'b0;
         burst_left = 0;
         // sender holds off until the pipeline is empty
         drain();
      end

      if (error_count == 0) begin
         $display("gaussian_polar_sampler_tb: clean");
      end else begin
         $display("gaussian_polar_sampler_tb: errors");
      end
      $finish;
   end

endmodule
